// ===== sv/psvm_pkg.sv =====
// Package: shared types and constants for the polyphonic sample voice mixer.
`timescale 1ns / 1ps
package psvm_pkg;

  localparam logic [1:0] CMD_WAVE     = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd2;
  localparam logic [1:0] CMD_RENDER   = 2'd3;

  localparam logic [1:0] PH_OFF     = 2'd0;
  localparam logic [1:0] PH_ATTACK  = 2'd1;
  localparam logic [1:0] PH_SUSTAIN = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  localparam logic [2:0] REG_SAMPLE_LENGTH = 3'd0;
  localparam logic [2:0] REG_TRIGGER_MODE  = 3'd1;
  localparam logic [2:0] REG_VOLUME        = 3'd2;
  localparam logic [2:0] REG_ATTACK_STEP   = 3'd3;
  localparam logic [2:0] REG_RELEASE_STEP  = 3'd4;
  localparam logic [2:0] REG_MIDI_CHANNEL  = 3'd5;
  localparam logic [2:0] REG_NOTE_LOW      = 3'd6;
  localparam logic [2:0] REG_NOTE_HIGH     = 3'd7;

  // x/127 for x < 2^23 as (x * PEAK_RECIP) >> PEAK_SHIFT, exact over that range
  localparam logic [23:0] PEAK_RECIP = 24'd8454661;
  localparam int          PEAK_SHIFT = 30;

  typedef struct packed {
    logic [14:0] sample_length;
    logic [1:0]  trigger_mode;
    logic [15:0] volume;
    logic [15:0] attack_step;
    logic [15:0] release_step;
    logic [3:0]  midi_channel;
    logic [6:0]  note_low;
    logic [6:0]  note_high;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [13:0]        wave_address;
    logic signed [15:0] wave_data;
    logic [3:0]         channel;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic [19:0]        note_step;
  } item_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic               clipped;
  } result_t;

  // position keeps one spare integer bit so the end mark fits
  typedef struct packed {
    logic [1:0]  phase;
    logic [30:0] position;
    logic [19:0] step;
    logic [15:0] amplitude;
    logic [15:0] peak;
    logic [6:0]  note;
  } voice_t;

  // head cell to the interpolation pipeline
  typedef struct packed {
    logic        active;
    logic [15:0] amplitude;
    logic [15:0] frac;
    logic [14:0] idx0;
    logic [15:0] idx1;
    logic        ok0;
    logic        ok1;
  } tap_t;

endpackage

// ===== sv/psvm_cell.sv =====
// One voice cell of the rotating voice ring.
`timescale 1ns / 1ps
module psvm_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  psvm_pkg::voice_t d,
  output psvm_pkg::voice_t q
);
  import psvm_pkg::*;

  voice_t v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (shift) begin
      v <= d;
    end
  end

  assign q = v;
endmodule

// ===== sv/psvm_head.sv =====
// Voice update at the head of the ring: note on/off, wrap, envelope, taps.
`timescale 1ns / 1ps
module psvm_head #(
  parameter int WAVE_DEPTH = 16384
) (
  input  logic [1:0]       op,
  input  logic             hit,
  input  logic             claimed,
  input  logic [6:0]       note,
  input  logic [19:0]      note_step,
  input  logic [22:0]      peak_x,
  input  psvm_pkg::cfg_t   cfg,
  input  psvm_pkg::voice_t cur,
  output psvm_pkg::voice_t nxt,
  output logic             claim,
  output psvm_pkg::tap_t   tap
);
  import psvm_pkg::*;

  logic [46:0] peak_prod;
  logic [30:0] limit;
  logic [30:0] pos;
  logic        stop;
  logic [16:0] att_sum;
  logic [31:0] adv;
  logic [14:0] idx;
  logic [15:0] idx_n;

  assign peak_prod = 47'(peak_x) * 47'(PEAK_RECIP);
  assign limit     = {cfg.sample_length, 16'h0000};

  always_comb begin
    nxt     = cur;
    claim   = 1'b0;
    tap     = '0;
    pos     = cur.position;
    stop    = 1'b0;
    att_sum = 17'({1'b0, cur.amplitude}) + 17'(cfg.attack_step);
    adv     = '0;
    idx     = '0;
    idx_n   = '0;
    case (op)
      CMD_NOTE_ON: begin
        if (hit && !claimed && cur.phase == PH_OFF) begin
          nxt.phase     = PH_ATTACK;
          nxt.position  = '0;
          nxt.step      = note_step;
          nxt.amplitude = '0;
          nxt.peak      = peak_prod[PEAK_SHIFT+15:PEAK_SHIFT];
          nxt.note      = note;
          claim         = 1'b1;
        end
      end
      CMD_NOTE_OFF: begin
        if (hit && cur.phase != PH_OFF && cur.note == note) begin
          nxt.phase = PH_RELEASE;
        end
      end
      CMD_RENDER: begin
        if (cur.phase != PH_OFF) begin
          if (pos >= limit) begin
            pos = '0;
            if (cfg.trigger_mode != 2'd0) begin
              nxt.phase = PH_OFF;
              stop      = 1'b1;
            end
          end
          nxt.position = pos;
          if (!stop) begin
            case (cur.phase)
              PH_ATTACK: begin
                if (att_sum >= {1'b0, cur.peak}) begin
                  nxt.amplitude = cur.peak;
                  nxt.phase     = PH_SUSTAIN;
                end else begin
                  nxt.amplitude = att_sum[15:0];
                end
              end
              PH_RELEASE: begin
                if (cur.amplitude < cfg.release_step) begin
                  nxt.amplitude = '0;
                  nxt.phase     = PH_OFF;
                end else begin
                  nxt.amplitude = cur.amplitude - cfg.release_step;
                end
              end
              default: ;
            endcase
            idx   = pos[30:16];
            idx_n = 16'(idx) + 16'd1;
            tap.active    = 1'b1;
            tap.amplitude = nxt.amplitude;
            tap.frac      = pos[15:0];
            tap.idx0      = idx;
            tap.idx1      = idx_n;
            tap.ok0       = (idx < cfg.sample_length) && (32'(idx) < 32'(WAVE_DEPTH));
            tap.ok1       = (idx_n < 16'(cfg.sample_length)) &&
                            (32'(idx_n) < 32'(WAVE_DEPTH));
            adv = 32'(pos) + 32'(cur.step);
            nxt.position = (adv > 32'(limit)) ? limit : adv[30:0];
          end
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== sv/psvm_cfg.sv =====
// Configuration register bank behind the APB-style port.
`timescale 1ns / 1ps
module psvm_cfg (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output psvm_pkg::cfg_t cfg
);
  import psvm_pkg::*;

  cfg_t       regs;
  logic [2:0] sel;

  assign sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sample_length <= 15'd16384;
      regs.trigger_mode  <= 2'd0;
      regs.volume        <= 16'hFFFF;
      regs.attack_step   <= 16'hFFFF;
      regs.release_step  <= 16'hFFFF;
      regs.midi_channel  <= 4'd0;
      regs.note_low      <= 7'd0;
      regs.note_high     <= 7'd127;
    end else if (psel && penable && pwrite) begin
      case (sel)
        REG_SAMPLE_LENGTH: regs.sample_length <= pwdata[14:0];
        REG_TRIGGER_MODE:  regs.trigger_mode  <= pwdata[1:0];
        REG_VOLUME:        regs.volume        <= pwdata[15:0];
        REG_ATTACK_STEP:   regs.attack_step   <= pwdata[15:0];
        REG_RELEASE_STEP:  regs.release_step  <= pwdata[15:0];
        REG_MIDI_CHANNEL:  regs.midi_channel  <= pwdata[3:0];
        REG_NOTE_LOW:      regs.note_low      <= pwdata[6:0];
        REG_NOTE_HIGH:     regs.note_high     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_SAMPLE_LENGTH: prdata = 32'(regs.sample_length);
      REG_TRIGGER_MODE:  prdata = 32'(regs.trigger_mode);
      REG_VOLUME:        prdata = 32'(regs.volume);
      REG_ATTACK_STEP:   prdata = 32'(regs.attack_step);
      REG_RELEASE_STEP:  prdata = 32'(regs.release_step);
      REG_MIDI_CHANNEL:  prdata = 32'(regs.midi_channel);
      REG_NOTE_LOW:      prdata = 32'(regs.note_low);
      REG_NOTE_HIGH:     prdata = 32'(regs.note_high);
      default:           prdata = '0;
    endcase
  end

  assign cfg = regs;
endmodule

// ===== sv/polyphonic_sample_voice_mixer.sv =====
// Top level: voice ring, wave memory, interpolation pipeline and mix.
// Wave write: busy never rises. Note-on/off: busy while the ring rotates once.
// Render: rotate the ring, drain the pipeline through B, C and D, then saturate;
// the result strobe and the result are registered together from the finish state.
// The ring rotates one voice a cycle through the head; busy holds off new items until idle.
// Synchronous reset turns every voice off and restores register defaults;
// the wave memory is not cleared. The receiver cannot stall results.
`timescale 1ns / 1ps
module polyphonic_sample_voice_mixer #(
  parameter int NUM_VOICES = 8,
  parameter int WAVE_DEPTH = 16384
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  psvm_pkg::item_t   item,
  output logic              result_valid,
  output psvm_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import psvm_pkg::*;

  localparam int AW    = $clog2(WAVE_DEPTH);
  localparam int CW    = $clog2(NUM_VOICES) + 2;
  localparam int ACC_W = 18 + $clog2(NUM_VOICES) + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  cfg_t cfg;

  psvm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );
  assign pready = 1'b1;

  // ---------------- control ----------------
  logic [1:0]    state;
  logic [CW-1:0] cnt;
  logic          accept;
  logic          running;

  // latched transaction
  logic [1:0]  op;
  logic        hit;
  logic        claimed;
  logic [6:0]  op_note;
  logic [19:0] op_step;
  logic [22:0] peak_x;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign running = (state == ST_RUN);

  // ---------------- voice ring ----------------
  // Voice v sits in cell NUM_VOICES-1-v, so the head sees voices in order
  // and a full rotation puts every voice back in place.
  voice_t cell_q [NUM_VOICES];
  voice_t head_nxt;
  logic   claim;
  tap_t   tap;

  for (genvar i = 0; i < NUM_VOICES; i++) begin : g_ring
    if (i == 0) begin : g_first
      psvm_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (running),
        .d     (head_nxt),
        .q     (cell_q[i])
      );
    end else begin : g_rest
      psvm_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (running),
        .d     (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

  psvm_head #(
    .WAVE_DEPTH (WAVE_DEPTH)
  ) u_head (
    .op        (op),
    .hit       (hit),
    .claimed   (claimed),
    .note      (op_note),
    .note_step (op_step),
    .peak_x    (peak_x),
    .cfg       (cfg),
    .cur       (cell_q[NUM_VOICES-1]),
    .nxt       (head_nxt),
    .claim     (claim),
    .tap       (tap)
  );

  // ---------------- wave memory ----------------
  logic [15:0] wave_mem [WAVE_DEPTH];
  logic [31:0] wr_addr;
  logic [31:0] rd_addr0;
  logic [31:0] rd_addr1;
  logic [15:0] rd0;
  logic [15:0] rd1;

  assign wr_addr  = 32'(item.wave_address);
  assign rd_addr0 = 32'(tap.idx0);
  assign rd_addr1 = 32'(tap.idx1);

  always_ff @(posedge clk) begin
    if (accept && item.cmd == CMD_WAVE && wr_addr < 32'(WAVE_DEPTH)) begin
      wave_mem[wr_addr[AW-1:0]] <= item.wave_data;
    end
  end

  always_ff @(posedge clk) begin
    rd0 <= wave_mem[rd_addr0[AW-1:0]];
    rd1 <= wave_mem[rd_addr1[AW-1:0]];
  end

  // ---------------- interpolation pipeline ----------------
  // B: s0*(1-f) + s1*f;  C: times amplitude, floor by 2^32;  D: accumulate.
  logic        b_valid;
  logic [15:0] b_amp;
  logic [15:0] b_frac;
  logic        b_ok0;
  logic        b_ok1;

  logic signed [15:0] s0;
  logic signed [15:0] s1;
  logic signed [33:0] interp;

  logic               c_valid;
  logic signed [33:0] c_interp;
  logic [15:0]        c_amp;
  logic signed [50:0] prod;

  logic               d_valid;
  logic signed [17:0] d_contrib;

  logic signed [ACC_W-1:0] acc;

  assign s0     = b_ok0 ? $signed(rd0) : 16'sd0;
  assign s1     = b_ok1 ? $signed(rd1) : 16'sd0;
  assign interp = 34'(s0 * $signed({1'b0, 17'h10000 - 17'(b_frac)}))
                + 34'(s1 * $signed({2'b00, b_frac}));
  assign prod   = 51'(c_interp * $signed({1'b0, c_amp}));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      b_valid <= running && tap.active;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
    b_amp     <= tap.amplitude;
    b_frac    <= tap.frac;
    b_ok0     <= tap.ok0;
    b_ok1     <= tap.ok1;
    c_interp  <= interp;
    c_amp     <= b_amp;
    d_contrib <= prod[49:32];
  end

  // ---------------- sequencing ----------------
  logic signed [ACC_W-1:0] max_s;
  logic signed [ACC_W-1:0] min_s;

  assign max_s = ACC_W'(32767);
  assign min_s = -ACC_W'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
      op           <= CMD_WAVE;
      hit          <= 1'b0;
      claimed      <= 1'b0;
      acc          <= '0;
    end else begin
      result_valid <= 1'b0;
      if (d_valid) begin
        acc <= acc + ACC_W'(d_contrib);
      end
      case (state)
        ST_IDLE: begin
          if (accept && item.cmd != CMD_WAVE) begin
            state   <= ST_RUN;
            cnt     <= '0;
            op      <= item.cmd;
            claimed <= 1'b0;
            acc     <= '0;
            if (item.cmd == CMD_NOTE_ON) begin
              hit <= (item.channel == cfg.midi_channel) &&
                     (item.note >= cfg.note_low) && (item.note <= cfg.note_high);
            end else begin
              hit <= (item.channel == cfg.midi_channel) && (cfg.trigger_mode < 2'd2);
            end
          end
        end
        ST_RUN: begin
          if (claim) begin
            claimed <= 1'b1;
          end
          if (cnt == CW'(NUM_VOICES - 1)) begin
            cnt   <= '0;
            state <= (op == CMD_RENDER) ? ST_DRAIN : ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (cnt == CW'(2)) begin
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload of the latched transaction and the result
  always_ff @(posedge clk) begin
    if (accept) begin
      op_note <= item.note;
      op_step <= item.note_step;
      peak_x  <= 23'(cfg.volume) * 23'(item.velocity);
    end
    if (state == ST_FINISH) begin
      if (acc > max_s) begin
        result.mixed_sample <= 16'sh7FFF;
        result.clipped      <= 1'b1;
      end else if (acc < min_s) begin
        result.mixed_sample <= -16'sh8000;
        result.clipped      <= 1'b1;
      end else begin
        result.mixed_sample <= acc[15:0];
        result.clipped      <= 1'b0;
      end
    end
  end

  // ---------------- assertions ----------------
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_after_finish: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_FINISH))
    else $error("result without a finished render");

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!b_valid && !c_valid && !d_valid))
    else $error("pipeline busy while idle");

  a_single_claim: assert property (@(posedge clk) disable iff (rst)
    (running && claimed) |-> !claim)
    else $error("note-on claimed two voices");
endmodule
